// ===== rtl/core/lease_client_state_machine_unit_macros.svh =====
// Assertion macros used by the lease client checker
`ifndef LEASE_CLIENT_STATE_MACHINE_UNIT_MACROS_SVH
`define LEASE_CLIENT_STATE_MACHINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LCSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define LCSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lcsm_pkg.sv =====
// Types, codes and helpers of the lease client state machine
package lcsm_pkg;

	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_MSG     = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;
	localparam logic [1:0] CMD_RELEASE = 2'd3;

	localparam logic [1:0] MT_OFFER = 2'd0;
	localparam logic [1:0] MT_ACK   = 2'd1;

	localparam logic [2:0] KIND_START   = 3'd0;
	localparam logic [2:0] KIND_OFFER   = 3'd1;
	localparam logic [2:0] KIND_ACK     = 3'd2;
	localparam logic [2:0] KIND_OTHER   = 3'd3;
	localparam logic [2:0] KIND_TICK    = 3'd4;
	localparam logic [2:0] KIND_RELEASE = 3'd5;

	localparam logic [2:0] PH_INIT    = 3'd0;
	localparam logic [2:0] PH_WOFFER  = 3'd1;
	localparam logic [2:0] PH_WACK    = 3'd2;
	localparam logic [2:0] PH_INUSE   = 3'd3;
	localparam logic [2:0] PH_WOFFER2 = 3'd4;
	localparam logic [2:0] PH_WACK2   = 3'd5;
	localparam logic [2:0] PH_WEXT    = 3'd6;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_REFUSED  = 3'd1;
	localparam logic [2:0] EV_WRONG    = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_NOLEASE  = 3'd4;
	localparam logic [2:0] EV_RELEASED = 3'd5;
	localparam logic [2:0] EV_IGNORED  = 3'd6;

	localparam logic [1:0] SEND_DISC    = 2'd0;
	localparam logic [1:0] SEND_REQUEST = 2'd1;
	localparam logic [1:0] SEND_RELEASE = 2'd2;

	localparam logic [1:0] CODE_NONE   = 2'd0;
	localparam logic [1:0] CODE_FIRST  = 2'd1;
	localparam logic [1:0] CODE_EXTEND = 2'd2;

	localparam logic [15:0] WAIT_TIMEOUT_RST = 16'd10;

	typedef struct packed {
		logic [2:0]  kind;
		logic        granted;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [15:0] ticks;
	} lcsm_item_t;

	typedef struct packed {
		logic        stopped;
		logic [2:0]  event_code;
		logic [2:0]  client_state;
		logic [31:0] send_mask;
		logic [31:0] send_addr;
		logic [15:0] send_time;
		logic [1:0]  send_code;
		logic [1:0]  send_type;
		logic        send_valid;
	} lcsm_result_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ===== rtl/core/lcsm_front.sv =====
// Front end: accept requests and classify them into queue items
module lcsm_front import lcsm_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        q_full,
	output logic        q_push,
	output lcsm_item_t  q_item
);

	logic [1:0] msg_type;

	assign msg_type = s_tdata[1:0];
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.granted = (s_tdata[9:2] == 8'd0);
		q_item.addr    = s_tdata[41:10];
		q_item.mask    = s_tdata[73:42];
		q_item.ticks   = s_tdata[89:74];
		unique case (s_tuser)
			CMD_START:   q_item.kind = KIND_START;
			CMD_MSG: begin
				if (msg_type == MT_OFFER)
					q_item.kind = KIND_OFFER;
				else if (msg_type == MT_ACK)
					q_item.kind = KIND_ACK;
				else
					q_item.kind = KIND_OTHER;
			end
			CMD_TICK:    q_item.kind = KIND_TICK;
			CMD_RELEASE: q_item.kind = KIND_RELEASE;
			default:     q_item.kind = KIND_TICK;
		endcase
	end

endmodule

// ===== rtl/core/lcsm_queue.sv =====
// Short queue of classified requests between front and back ends
module lcsm_queue import lcsm_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lcsm_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output lcsm_item_t head_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lcsm_item_t    entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign valid     = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && valid;
	assign head_item = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== rtl/core/lcsm_back.sv =====
// Back end: lease state machine, countdown and result register
module lcsm_back import lcsm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         q_valid,
	input  lcsm_item_t   q_item,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_ready,
	output lcsm_result_t out_result
);

	logic [15:0]  wait_timeout_q;
	logic [2:0]   phase_q;
	logic [15:0]  countdown_q;
	logic [31:0]  lease_addr_q;
	logic [31:0]  lease_mask_q;
	logic [15:0]  granted_q;
	logic [15:0]  last_time_q;
	logic         halted_q;
	logic         out_valid_q;
	lcsm_result_t res_q;

	logic [2:0]   ph_n;
	logic [15:0]  cd_n;
	logic [15:0]  cd_dec;
	logic [31:0]  addr_n;
	logic [31:0]  mask_n;
	logic [15:0]  gr_n;
	logic [15:0]  lt_n;
	logic         halt_n;
	logic [2:0]   ev;
	lcsm_result_t res;

	assign q_pop      = q_valid && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_result = res_q;
	assign cd_dec     = (countdown_q != 16'd0) ? countdown_q - 16'd1 : 16'd0;

	always_comb begin
		ph_n   = phase_q;
		cd_n   = countdown_q;
		addr_n = lease_addr_q;
		mask_n = lease_mask_q;
		gr_n   = granted_q;
		lt_n   = last_time_q;
		halt_n = halted_q;
		ev     = EV_NONE;
		res    = '0;
		if (halted_q) begin
			ev = EV_IGNORED;
		end else begin
			unique case (q_item.kind)
				KIND_START: begin
					if (phase_q == PH_INIT) begin
						res.send_valid = 1'b1;
						res.send_type  = SEND_DISC;
						res.send_code  = CODE_NONE;
						cd_n           = wait_timeout_q;
						ph_n           = PH_WOFFER;
					end else begin
						ev = EV_IGNORED;
					end
				end
				KIND_OFFER, KIND_ACK, KIND_OTHER: begin
					lt_n = q_item.ticks;
					priority if (phase_q == PH_WOFFER || phase_q == PH_WOFFER2) begin
						if (q_item.kind != KIND_OFFER) begin
							halt_n = 1'b1;
							ev     = EV_WRONG;
						end else if (!q_item.granted) begin
							ev = EV_REFUSED;
						end else begin
							addr_n         = swap32(q_item.addr);
							mask_n         = swap32(q_item.mask);
							res.send_valid = 1'b1;
							res.send_type  = SEND_REQUEST;
							res.send_code  = CODE_FIRST;
							res.send_time  = q_item.ticks;
							res.send_addr  = q_item.addr;
							res.send_mask  = q_item.mask;
							ph_n           = PH_WACK;
						end
					end else if (phase_q == PH_WACK || phase_q == PH_WEXT ||
							phase_q == PH_INUSE || phase_q == PH_WACK2) begin
						if (q_item.kind != KIND_ACK) begin
							halt_n = 1'b1;
							ev     = EV_WRONG;
						end else if (!q_item.granted) begin
							ev = EV_REFUSED;
						end else begin
							addr_n = q_item.addr;
							mask_n = q_item.mask;
							if (phase_q == PH_WACK || phase_q == PH_WEXT)
								gr_n = q_item.ticks;
							cd_n = {1'b0, q_item.ticks[15:1]};
							ph_n = PH_INUSE;
						end
					end else begin
						halt_n = 1'b1;
						ev     = EV_WRONG;
					end
				end
				KIND_TICK: begin
					cd_n = cd_dec;
					if (cd_dec == 16'd0) begin
						unique case (phase_q)
							PH_WOFFER: begin
								res.send_valid = 1'b1;
								res.send_type  = SEND_DISC;
								res.send_code  = CODE_EXTEND;
								cd_n           = wait_timeout_q;
								ph_n           = PH_WOFFER2;
								ev             = EV_TIMEOUT;
							end
							PH_WACK: begin
								res.send_valid = 1'b1;
								res.send_type  = SEND_REQUEST;
								res.send_code  = CODE_FIRST;
								res.send_time  = last_time_q;
								res.send_addr  = swap32(lease_addr_q);
								res.send_mask  = swap32(lease_mask_q);
								cd_n           = wait_timeout_q;
								ph_n           = PH_WACK2;
								ev             = EV_TIMEOUT;
							end
							PH_INUSE: begin
								res.send_valid = 1'b1;
								res.send_type  = SEND_REQUEST;
								res.send_code  = CODE_EXTEND;
								res.send_time  = granted_q;
								res.send_addr  = lease_addr_q;
								res.send_mask  = lease_mask_q;
								cd_n           = {1'b0, granted_q[15:1]};
								ph_n           = PH_WACK2;
							end
							PH_WOFFER2, PH_WACK2, PH_WEXT: begin
								halt_n = 1'b1;
								ev     = EV_TIMEOUT;
							end
							default: begin
								ev = EV_NONE;
							end
						endcase
					end
				end
				KIND_RELEASE: begin
					if (phase_q == PH_INUSE || phase_q == PH_WEXT) begin
						res.send_valid = 1'b1;
						res.send_type  = SEND_RELEASE;
						res.send_code  = CODE_NONE;
						res.send_addr  = lease_addr_q;
						ev             = EV_RELEASED;
					end else begin
						ev = EV_NOLEASE;
					end
					halt_n = 1'b1;
				end
				default: begin
					ev = EV_NONE;
				end
			endcase
		end
		res.client_state = ph_n;
		res.event_code   = ev;
		res.stopped      = halt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_timeout_q <= WAIT_TIMEOUT_RST;
			phase_q        <= PH_INIT;
			countdown_q    <= WAIT_TIMEOUT_RST;
			lease_addr_q   <= '0;
			lease_mask_q   <= '0;
			granted_q      <= '0;
			last_time_q    <= '0;
			halted_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we)
				wait_timeout_q <= cfg_wdata;
			if (q_pop) begin
				phase_q      <= ph_n;
				countdown_q  <= cd_n;
				lease_addr_q <= addr_n;
				lease_mask_q <= mask_n;
				granted_q    <= gr_n;
				last_time_q  <= lt_n;
				halted_q     <= halt_n;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			res_q <= res;
	end

endmodule

// ===== rtl/core/lease_client_state_machine_unit.sv =====
// Top level of the lease client state machine
// Takes one request per cycle while the queue has room and returns exactly one
// result per request, in order; the sustained rate is one request per cycle
// while m_tready is high. An accepted request is written into the queue, then
// the back end pops it and registers its result. A QUEUE_DEPTH-entry queue lets
// requests keep arriving while a result waits on m_tready. The wait timeout
// register (reset 10) is written through cfg_we/cfg_wdata; the user must write
// it only while no request is pending, as the block does not enforce this.
module lease_client_state_machine_unit import lcsm_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// msg_type[1:0], msg_code[9:2], offered_addr[41:10], offered_mask[73:42],
	// offered_time[89:74], zero fill
	input  logic [95:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// send_valid[0], send_type[2:1], send_code[4:3], send_time[20:5],
	// send_addr[52:21], send_mask[84:53], client_state[87:85],
	// event_code[90:88], stopped[91], zero fill
	output logic [95:0] m_tdata
);

	lcsm_item_t   push_item;
	lcsm_item_t   head_item;
	lcsm_result_t result;
	logic         q_push;
	logic         q_full;
	logic         q_valid;
	logic         q_pop;

	lcsm_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	lcsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head_item (head_item)
	);

	lcsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_valid    (q_valid),
		.q_item     (head_item),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {4'd0, result};

endmodule

// ===== rtl/core/lcsm_checker.sv =====
// Port checker for the lease client state machine and its bind
`include "lease_client_state_machine_unit_macros.svh"

module lcsm_checker import lcsm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	logic       send_valid;
	logic [1:0] send_type;
	logic [2:0] event_code;
	logic       stopped;

	assign send_valid = m_tdata[0];
	assign send_type  = m_tdata[2:1];
	assign event_code = m_tdata[90:88];
	assign stopped    = m_tdata[91];

	`LCSM_ASSERT_NOW(a_idle_fields_zero, m_tvalid && !send_valid, m_tdata[84:1] == 84'd0, "send fields not zero without send")
	`LCSM_ASSERT_NOW(a_release_sends, m_tvalid && event_code == EV_RELEASED, send_valid && send_type == SEND_RELEASE && stopped, "release result malformed")
	`LCSM_ASSERT_NOW(a_stop_has_event, m_tvalid && stopped, event_code != EV_NONE, "stopped result without event")
	`LCSM_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind lease_client_state_machine_unit lcsm_checker u_lcsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/lease_client_tracker.sv =====
// Request and result watcher that predicts every lease client result and checks it
module lease_client_tracker import lcsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// msg_type[1:0], msg_code[9:2], offered_addr[41:10], offered_mask[73:42],
	// offered_time[89:74], zero fill
	input  logic [95:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// send_valid[0], send_type[2:1], send_code[4:3], send_time[20:5],
	// send_addr[52:21], send_mask[84:53], client_state[87:85],
	// event_code[90:88], stopped[91], zero fill
	input  logic [95:0] m_tdata,
	output int          mismatch_count,
	output int          replies_due
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0]  wait_ticks;
	logic [2:0]   phase;
	logic [15:0]  countdown;
	logic [31:0]  lease_addr;
	logic [31:0]  lease_mask;
	logic [15:0]  granted_ticks;
	logic [15:0]  last_msg_time;
	logic         halted;
	lcsm_result_t expected_replies[$];
	int           errors = 0;

	function automatic logic [31:0] byte_reverse(input logic [31:0] v);
		logic [31:0] r;
		for (int b = 0; b < 4; b++) begin
			r[8*b +: 8] = v[8*(3-b) +: 8];
		end
		return r;
	endfunction

	function automatic lcsm_result_t outgoing(input logic [1:0] kind, input logic [1:0] code,
			input logic [15:0] ltime, input logic [31:0] addr, input logic [31:0] mask);
		lcsm_result_t r;
		r = '0;
		r.send_valid = 1'b1;
		r.send_type = kind;
		r.send_code = code;
		r.send_time = ltime;
		r.send_addr = addr;
		r.send_mask = mask;
		return r;
	endfunction

	task automatic advance_lease(input logic [1:0] cmd, input logic [95:0] d,
			output lcsm_result_t r);
		logic [1:0]  mtype;
		logic [7:0]  mcode;
		logic [31:0] maddr;
		logic [31:0] mmask;
		logic [15:0] mtime;
		logic [2:0]  ev;
		logic        ack_first;
		mtype = d[1:0];
		mcode = d[9:2];
		maddr = d[41:10];
		mmask = d[73:42];
		mtime = d[89:74];
		r = '0;
		ev = EV_NONE;
		if (halted) begin
			ev = EV_IGNORED;
		end else begin
			case (cmd)
				CMD_START: begin
					if (phase == PH_INIT) begin
						r = outgoing(SEND_DISC, CODE_NONE, 16'd0, 32'd0, 32'd0);
						countdown = wait_ticks;
						phase = PH_WOFFER;
					end else begin
						ev = EV_IGNORED;
					end
				end
				CMD_MSG: begin
					last_msg_time = mtime;
					if (phase == PH_WOFFER || phase == PH_WOFFER2) begin
						if (mtype != MT_OFFER) begin
							halted = 1'b1;
							ev = EV_WRONG;
						end else if (mcode != 8'd0) begin
							ev = EV_REFUSED;
						end else begin
							lease_addr = byte_reverse(maddr);
							lease_mask = byte_reverse(mmask);
							r = outgoing(SEND_REQUEST, CODE_FIRST, mtime, maddr, mmask);
							phase = PH_WACK;
						end
					end else if (phase == PH_WACK || phase == PH_WEXT || phase == PH_INUSE ||
							phase == PH_WACK2) begin
						ack_first = (phase == PH_WACK || phase == PH_WEXT);
						if (mtype != MT_ACK) begin
							halted = 1'b1;
							ev = EV_WRONG;
						end else if (mcode != 8'd0) begin
							ev = EV_REFUSED;
						end else begin
							lease_addr = maddr;
							lease_mask = mmask;
							if (ack_first) begin
								granted_ticks = mtime;
							end
							countdown = mtime >> 1;
							phase = PH_INUSE;
						end
					end else begin
						halted = 1'b1;
						ev = EV_WRONG;
					end
				end
				CMD_TICK: begin
					if (countdown != 16'd0) begin
						countdown = countdown - 16'd1;
					end
					if (countdown == 16'd0) begin
						case (phase)
							PH_WOFFER: begin
								r = outgoing(SEND_DISC, CODE_EXTEND, 16'd0, 32'd0, 32'd0);
								countdown = wait_ticks;
								phase = PH_WOFFER2;
								ev = EV_TIMEOUT;
							end
							PH_WACK: begin
								r = outgoing(SEND_REQUEST, CODE_FIRST, last_msg_time,
									byte_reverse(lease_addr), byte_reverse(lease_mask));
								countdown = wait_ticks;
								phase = PH_WACK2;
								ev = EV_TIMEOUT;
							end
							PH_INUSE: begin
								r = outgoing(SEND_REQUEST, CODE_EXTEND, granted_ticks,
									lease_addr, lease_mask);
								countdown = granted_ticks >> 1;
								phase = PH_WACK2;
							end
							PH_WOFFER2, PH_WACK2, PH_WEXT: begin
								halted = 1'b1;
								ev = EV_TIMEOUT;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					if (phase == PH_INUSE || phase == PH_WEXT) begin
						r = outgoing(SEND_RELEASE, CODE_NONE, 16'd0, lease_addr, 32'd0);
						ev = EV_RELEASED;
					end else begin
						ev = EV_NOLEASE;
					end
					halted = 1'b1;
				end
			endcase
		end
		r.client_state = phase;
		r.event_code = ev;
		r.stopped = halted;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lcsm_result_t want;
		lcsm_result_t got;
		if (!arst_n) begin
			wait_ticks = WAIT_TIMEOUT_RST;
			phase = PH_INIT;
			countdown = WAIT_TIMEOUT_RST;
			lease_addr = '0;
			lease_mask = '0;
			granted_ticks = '0;
			last_msg_time = '0;
			halted = 1'b0;
			expected_replies.delete();
			replies_due <= 0;
		end else begin
			if (cfg_we) begin
				wait_ticks = cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[91:0];
				if (expected_replies.size() == 0) begin
					$error("result with no request pending");
					errors++;
				end else begin
					want = expected_replies.pop_front();
					check_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
					check_field("send_type", 32'(want.send_type), 32'(got.send_type));
					check_field("send_code", 32'(want.send_code), 32'(got.send_code));
					check_field("send_time", 32'(want.send_time), 32'(got.send_time));
					check_field("send_addr", want.send_addr, got.send_addr);
					check_field("send_mask", want.send_mask, got.send_mask);
					check_field("client_state", 32'(want.client_state),
						32'(got.client_state));
					check_field("event_code", 32'(want.event_code), 32'(got.event_code));
					check_field("stopped", 32'(want.stopped), 32'(got.stopped));
				end
			end
			if (s_tvalid && s_tready) begin
				advance_lease(s_tuser, s_tdata, want);
				expected_replies.push_back(want);
			end
			replies_due <= expected_replies.size();
		end
		mismatch_count <= errors;
	end

endmodule

// ===== bench/tb_lease_client_state_machine_unit.sv =====
// Testbench top: drives lease client requests and register writes, gives the verdict
module tb_lease_client_state_machine_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import lcsm_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 200;

	typedef enum int {
		END_RELEASE_HELD,
		END_RELEASE_EMPTY,
		END_WRONG_KIND,
		END_RETRY_EXPIRY,
		END_EARLY_MSG
	} finale_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	int          mismatch_count;
	int          replies_due;

	logic [2:0]  gen_phase = PH_INIT;
	logic [15:0] gen_cd = WAIT_TIMEOUT_RST;
	logic [15:0] gen_granted = '0;
	logic [15:0] gen_wait = WAIT_TIMEOUT_RST;
	logic        gen_halted = 1'b0;
	bit          sender_gaps = 1'b0;
	bit          receiver_stalls = 1'b0;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	lease_client_state_machine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	lease_client_tracker u_tracker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.replies_due    (replies_due)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (receiver_stalls && $urandom_range(0, 15) == 0) begin
			stall_left <= $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// follow phase and countdown so that random requests keep the client alive
	task automatic track(input logic [1:0] cmd, input logic [1:0] mtype,
			input logic [7:0] mcode, input logic [15:0] ltime);
		if (!gen_halted) begin
			case (cmd)
				CMD_START: begin
					if (gen_phase == PH_INIT) begin
						gen_phase = PH_WOFFER;
						gen_cd = gen_wait;
					end
				end
				CMD_MSG: begin
					if (gen_phase == PH_WOFFER || gen_phase == PH_WOFFER2) begin
						if (mtype != MT_OFFER) begin
							gen_halted = 1'b1;
						end else if (mcode == 8'd0) begin
							gen_phase = PH_WACK;
						end
					end else if (gen_phase != PH_INIT) begin
						if (mtype != MT_ACK) begin
							gen_halted = 1'b1;
						end else if (mcode == 8'd0) begin
							if (gen_phase == PH_WACK) begin
								gen_granted = ltime;
							end
							gen_cd = ltime >> 1;
							gen_phase = PH_INUSE;
						end
					end else begin
						gen_halted = 1'b1;
					end
				end
				CMD_TICK: begin
					if (gen_cd != 16'd0) begin
						gen_cd = gen_cd - 16'd1;
					end
					if (gen_cd == 16'd0) begin
						if (gen_phase == PH_WOFFER) begin
							gen_phase = PH_WOFFER2;
							gen_cd = gen_wait;
						end else if (gen_phase == PH_WACK) begin
							gen_phase = PH_WACK2;
							gen_cd = gen_wait;
						end else if (gen_phase == PH_INUSE) begin
							gen_phase = PH_WACK2;
							gen_cd = gen_granted >> 1;
						end else if (gen_phase != PH_INIT) begin
							gen_halted = 1'b1;
						end
					end
				end
				default: begin
					gen_halted = 1'b1;
				end
			endcase
		end
	endtask

	task automatic issue(input logic [1:0] cmd, input logic [1:0] mtype,
			input logic [7:0] mcode, input logic [31:0] addr, input logic [31:0] mask,
			input logic [15:0] ltime);
		int gap;
		if (sender_gaps && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, ltime, mask, addr, mcode, mtype};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		track(cmd, mtype, mcode, ltime);
	endtask

	task automatic noise(input logic [1:0] cmd);
		issue(cmd, 2'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom,
			16'($urandom));
	endtask

	function automatic logic [15:0] lease_len();
		if ($urandom_range(0, 15) == 0) begin
			return 16'($urandom_range(0, 65535));
		end
		return 16'($urandom_range(0, 24));
	endfunction

	task automatic lease_step();
		int         pick;
		bit         tick_ok;
		logic [1:0] kind;
		pick = $urandom_range(0, 99);
		kind = (gen_phase == PH_WOFFER || gen_phase == PH_WOFFER2) ? MT_OFFER : MT_ACK;
		tick_ok = gen_phase == PH_WOFFER || gen_phase == PH_WACK || gen_phase == PH_INUSE ||
			gen_cd > 16'd1;
		if (gen_halted) begin
			noise(2'($urandom_range(0, 3)));
		end else if (gen_phase == PH_INIT || pick < 5) begin
			noise(CMD_START);
		end else if (tick_ok && pick < (gen_phase == PH_INUSE ? 75 : 55)) begin
			noise(CMD_TICK);
		end else if (pick % 3 == 0) begin
			issue(CMD_MSG, kind, 8'($urandom_range(1, 255)), $urandom, $urandom, lease_len());
		end else begin
			issue(CMD_MSG, kind, 8'd0, $urandom, $urandom, lease_len());
		end
	endtask

	task automatic set_wait(input logic [15:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_wait = value;
	endtask

	initial begin : stimulus
		finale_e     finale;
		logic [1:0]  bad_kind;
		logic [15:0] next_wait;
		finale = ($urandom_range(0, 11) == 0) ? END_EARLY_MSG : finale_e'($urandom_range(0, 3));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		if (finale == END_EARLY_MSG) begin
			issue(CMD_MSG, MT_ACK, 8'd0, $urandom, $urandom, 16'hFFFF);
		end
		issue(CMD_TICK, 2'd3, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		set_wait(16'($urandom_range(0, 3)));
		issue(CMD_START, 2'd0, 8'd0, 32'd0, 32'd0, 16'd0);
		issue(CMD_START, 2'd3, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		issue(CMD_MSG, MT_OFFER, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		if ($urandom_range(0, 1)) begin
			while (gen_phase == PH_WOFFER) noise(CMD_TICK);
		end
		issue(CMD_MSG, MT_OFFER, 8'd0, 32'h0123_4567, 32'hFFFF_FF00, 16'd9);
		issue(CMD_MSG, MT_ACK, 8'h80, 32'hFFFF_FFFF, 32'd0, 16'h8000);
		if ($urandom_range(0, 1)) begin
			while (gen_phase == PH_WACK) noise(CMD_TICK);
		end
		issue(CMD_MSG, MT_ACK, 8'd0, 32'hC0A8_0001, 32'hFFFF_FF00, 16'd8);
		issue(CMD_MSG, MT_ACK, 8'd0, 32'h0A00_0002, 32'hFF00_0000, 16'd3);
		while (gen_phase == PH_INUSE) noise(CMD_TICK);
		issue(CMD_MSG, MT_ACK, 8'd1, 32'd0, 32'd0, 16'd0);
		issue(CMD_MSG, MT_ACK, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: next_wait = 16'd0;
				1: next_wait = 16'hFFFF;
				2: next_wait = 16'd1;
				3: next_wait = 16'($urandom_range(2, 6));
				default: next_wait = 16'($urandom_range(0, 65535));
			endcase
			set_wait(next_wait);
			sender_gaps = (p != 2);
			receiver_stalls = (p != 3);
			repeat (PHASE_ITEMS) lease_step();
		end

		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		case (finale)
			END_RELEASE_HELD: begin
				while (!gen_halted && gen_phase != PH_INUSE) lease_step();
				noise(CMD_RELEASE);
			end
			END_RELEASE_EMPTY: begin
				while (!gen_halted && gen_phase == PH_INUSE) lease_step();
				noise(CMD_RELEASE);
			end
			END_WRONG_KIND: begin
				if (gen_phase == PH_WOFFER || gen_phase == PH_WOFFER2) begin
					bad_kind = 2'($urandom_range(1, 3));
				end else begin
					bad_kind = 2'($urandom_range(0, 2));
					if (bad_kind == MT_ACK) begin
						bad_kind = 2'd3;
					end
				end
				issue(CMD_MSG, bad_kind, 8'($urandom), $urandom, $urandom, 16'($urandom));
			end
			END_RETRY_EXPIRY: begin
				while (!gen_halted) noise(CMD_TICK);
			end
			default: begin
			end
		endcase
		repeat (12) noise(2'($urandom_range(0, 3)));

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && replies_due == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
